>>> hw/rtl/hmac_sha256_engine_core_defines.svh
// assertion macros for the hmac engine
`ifndef HMAC_SHA256_ENGINE_CORE_DEFINES_SVH
`define HMAC_SHA256_ENGINE_CORE_DEFINES_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPL(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error("%m failed");
`define ASSERT_NEVER(label, clk, rst_n, expr) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error("%m failed");
`else
`define ASSERT_IMPL(label, clk, rst_n, prop)
`define ASSERT_NEVER(label, clk, rst_n, expr)
`endif
`endif

>>> hw/rtl/hse_pkg.sv
package hse_pkg;

  localparam int unsigned NumKeyWords = 8;
  localparam int unsigned CfgIdxW = 3;

  localparam logic [7:0] Ipad = 8'h36;
  localparam logic [7:0] Opad = 8'h5c;
  localparam logic [7:0] PadByte = 8'h80;

  typedef logic [31:0] word_t;

  typedef struct packed {
    logic [7:0] msg_byte;
    logic       has_byte;
    logic       is_last;
  } in_item_t;

  typedef struct packed {
    logic [63:0] mac_word_0;
    logic [63:0] mac_word_1;
    logic [63:0] mac_word_2;
    logic [63:0] mac_word_3;
  } out_item_t;

  typedef struct packed {
    logic start;
    logic busy;
  } cmp_ctrl_t;

  localparam word_t InitHash [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam word_t RoundK [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

endpackage

>>> hw/rtl/hse_stream_if.sv
interface hse_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> hw/rtl/hmac_sha256_engine_core.sv
// sequence: each full 64-byte block in the message runs one compression (one sha-256 round per
// cycle in a shared round unit); the first item adds a compression of the inner key block;
// the last item adds 3 or 4 compressions and loads the 32-byte inner digest for the outer
// hash; the engine handles one transaction at a time
// reset: async active low; key registers clear, hash state returns to the sha-256 iv
`include "hmac_sha256_engine_core_defines.svh"

module hmac_sha256_engine_core (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [hse_pkg::CfgIdxW-1:0]        cfg_idx_i,
  input  logic [63:0]                        cfg_wdata_i,
  hse_stream_if.sink                         in_if,
  hse_stream_if.source                       out_if
);

  typedef enum logic [3:0] {
    StIdle, StKeyLoad, StKeyRun, StAbsorb, StBlkRun, StPad, StPadRun,
    StOuterKey, StOuterRun, StDigest, StOut
  } state_e;

  state_e state_q;
  logic [63:0] key_q [8];
  logic [511:0] buf_q;
  hse_pkg::word_t [7:0] hash_q, inner_q, hash_new;
  logic [60:0] cnt_q;
  logic        phase_q;
  logic        outer_q;
  logic        last_q;
  logic        second_q;
  logic [5:0]  dig_q;
  hse_pkg::in_item_t item_q;
  hse_pkg::out_item_t out_q;
  logic        out_valid_q;
  hse_pkg::cmp_ctrl_t cctl;
  logic        cmp_done;
  logic        start_q;
  logic [5:0]  idx;
  logic [63:0] bits;

  assign idx = cnt_q[5:0];
  assign bits = {cnt_q, 3'b000};
  assign cctl.start = start_q;
  assign cctl.busy = (state_q == StKeyRun) || (state_q == StBlkRun) ||
                     (state_q == StPadRun) || (state_q == StOuterRun);

  hse_compress u_cmp (
    .clk_i, .rst_ni, .ctrl_i(cctl), .block_i(buf_q), .hash_i(hash_q),
    .hash_o(hash_new), .done_o(cmp_done)
  );

  assign in_if.ready = (state_q == StIdle) && !out_valid_q;
  assign out_if.valid = out_valid_q;
  assign out_if.data = out_q;

  function automatic logic [511:0] key_block(input logic [63:0] k [8], input logic [7:0] p);
    logic [511:0] r;
    for (int i = 0; i < 8; i++) begin
      r[511 - 64*i -: 64] = k[i] ^ {8{p}};
    end
    return r;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 8; i++) key_q[i] <= '0;
    end else if (cfg_we_i) begin
      key_q[cfg_idx_i] <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      for (int i = 0; i < 8; i++) hash_q[i] <= hse_pkg::InitHash[i];
      cnt_q <= '0;
      phase_q <= 1'b0;
      outer_q <= 1'b0;
      last_q <= 1'b0;
      second_q <= 1'b0;
      dig_q <= '0;
      out_valid_q <= 1'b0;
      start_q <= 1'b0;
    end else begin
      start_q <= 1'b0;
      if (out_valid_q && out_if.ready) out_valid_q <= 1'b0;
      case (state_q)
        StIdle: begin
          if (in_if.valid && in_if.ready) begin
            item_q <= in_if.data;
            if (!phase_q) begin
              for (int i = 0; i < 8; i++) hash_q[i] <= hse_pkg::InitHash[i];
              buf_q <= key_block(key_q, hse_pkg::Ipad);
              start_q <= 1'b1;
              phase_q <= 1'b1;
              outer_q <= 1'b0;
              state_q <= StKeyRun;
            end else begin
              state_q <= StAbsorb;
            end
          end
        end
        StKeyRun: begin
          if (cmp_done) begin
            hash_q <= hash_new;
            cnt_q <= 61'd64;
            state_q <= StAbsorb;
          end
        end
        StAbsorb: begin
          if (item_q.has_byte) begin
            buf_q[511 - 8*idx -: 8] <= item_q.msg_byte;
            cnt_q <= cnt_q + 61'd1;
            item_q.has_byte <= 1'b0;
            if (idx == 6'd63) begin
              start_q <= 1'b1;
              state_q <= StBlkRun;
            end
          end else if (item_q.is_last) begin
            state_q <= StPad;
            second_q <= 1'b0;
          end else begin
            state_q <= StIdle;
          end
        end
        StBlkRun: begin
          if (cmp_done) begin
            hash_q <= hash_new;
            state_q <= StAbsorb;
          end
        end
        StPad: begin
          if (!second_q) begin
            for (int i = 0; i < 64; i++) begin
              if (i == idx) buf_q[511 - 8*i -: 8] <= hse_pkg::PadByte;
              else if (i > idx && (i < 56 || idx >= 6'd56)) buf_q[511 - 8*i -: 8] <= 8'h00;
            end
            if (idx < 6'd56) buf_q[63:0] <= bits;
            second_q <= (idx >= 6'd56);
          end else begin
            buf_q <= {448'd0, bits};
            second_q <= 1'b0;
          end
          start_q <= 1'b1;
          last_q <= !second_q && (idx < 6'd56) || second_q;
          state_q <= StPadRun;
        end
        StPadRun: begin
          if (cmp_done) begin
            if (!last_q) begin
              hash_q <= hash_new;
              state_q <= StPad;
            end else if (!outer_q) begin
              inner_q <= hash_new;
              for (int i = 0; i < 8; i++) hash_q[i] <= hse_pkg::InitHash[i];
              buf_q <= key_block(key_q, hse_pkg::Opad);
              outer_q <= 1'b1;
              state_q <= StOuterKey;
            end else begin
              hash_q <= hash_new;
              out_q.mac_word_0 <= {hash_new[0], hash_new[1]};
              out_q.mac_word_1 <= {hash_new[2], hash_new[3]};
              out_q.mac_word_2 <= {hash_new[4], hash_new[5]};
              out_q.mac_word_3 <= {hash_new[6], hash_new[7]};
              out_valid_q <= 1'b1;
              phase_q <= 1'b0;
              cnt_q <= '0;
              state_q <= StOut;
            end
          end
        end
        StOuterKey: begin
          start_q <= 1'b1;
          state_q <= StOuterRun;
        end
        StOuterRun: begin
          if (cmp_done) begin
            hash_q <= hash_new;
            cnt_q <= 61'd64;
            dig_q <= '0;
            state_q <= StDigest;
          end
        end
        StDigest: begin
          buf_q[511 - 8*dig_q -: 8] <= inner_q[dig_q[4:2]][31 - 8*dig_q[1:0] -: 8];
          cnt_q <= cnt_q + 61'd1;
          dig_q <= dig_q + 6'd1;
          if (dig_q == 6'd31) begin
            second_q <= 1'b0;
            state_q <= StPad;
          end
        end
        StOut: begin
          if (!out_valid_q || out_if.ready) state_q <= StIdle;
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  `ASSERT_NEVER(out_overwrite, clk_i, rst_ni, out_valid_q && state_q == StPadRun && cmp_done && outer_q)
  `ASSERT_IMPL(accept_only_idle, clk_i, rst_ni, in_if.ready |-> state_q == StIdle)
  `ASSERT_IMPL(out_has_phase_clear, clk_i, rst_ni, $rose(out_valid_q) |-> !phase_q && cnt_q == '0)

endmodule

>>> hw/rtl/hse_compress.sv
`include "hmac_sha256_engine_core_defines.svh"

module hse_compress (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  hse_pkg::cmp_ctrl_t        ctrl_i,
  input  logic [511:0]              block_i,
  input  hse_pkg::word_t [7:0]      hash_i,
  output hse_pkg::word_t [7:0]      hash_o,
  output logic                      done_o
);

  hse_pkg::word_t [15:0] w_q, w_d;
  hse_pkg::word_t [7:0]  v_q, v_d;
  logic [5:0] rnd_q, rnd_d;
  logic       run_q, run_d;
  logic       done_q, done_d;

  hse_pkg::word_t w15, w2, wn, s0, s1, t1, t2, wcur;

  always_comb begin
    w15 = w_q[1];
    w2 = w_q[14];
    s0 = {w15[6:0], w15[31:7]} ^ {w15[17:0], w15[31:18]} ^ (w15 >> 3);
    s1 = {w2[16:0], w2[31:17]} ^ {w2[18:0], w2[31:19]} ^ (w2 >> 10);
    wn = w_q[0] + s0 + w_q[9] + s1;
    wcur = w_q[0];
    t1 = v_q[7] + ({v_q[4][5:0], v_q[4][31:6]} ^ {v_q[4][10:0], v_q[4][31:11]}
         ^ {v_q[4][24:0], v_q[4][31:25]}) + ((v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]))
         + hse_pkg::RoundK[rnd_q] + wcur;
    t2 = ({v_q[0][1:0], v_q[0][31:2]} ^ {v_q[0][12:0], v_q[0][31:13]}
         ^ {v_q[0][21:0], v_q[0][31:22]})
         + ((v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]));
  end

  always_comb begin
    w_d = w_q;
    v_d = v_q;
    rnd_d = rnd_q;
    run_d = run_q;
    done_d = 1'b0;
    if (ctrl_i.start) begin
      for (int i = 0; i < 16; i++) begin
        w_d[i] = block_i[511 - 32*i -: 32];
      end
      v_d = hash_i;
      rnd_d = '0;
      run_d = 1'b1;
    end else if (run_q) begin
      v_d = {v_q[6:4], v_q[3] + t1, v_q[2:0], t1 + t2};
      for (int i = 0; i < 15; i++) begin
        w_d[i] = w_q[i+1];
      end
      w_d[15] = wn;
      rnd_d = rnd_q + 6'd1;
      if (rnd_q == 6'd63) begin
        run_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rnd_q <= '0;
      run_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      rnd_q <= rnd_d;
      run_q <= run_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    w_q <= w_d;
    v_q <= v_d;
  end

  for (genvar g = 0; g < 8; g++) begin : g_out
    assign hash_o[g] = hash_i[g] + v_q[g];
  end
  assign done_o = done_q;

  `ASSERT_NEVER(start_while_run, clk_i, rst_ni, ctrl_i.start && run_q)
  `ASSERT_IMPL(done_after_last, clk_i, rst_ni, (run_q && rnd_q == 6'd63) |=> done_q)
  `ASSERT_IMPL(done_ends_run, clk_i, rst_ni, done_q |-> !run_q)
  `ASSERT_IMPL(start_runs, clk_i, rst_ni, ctrl_i.start |=> run_q && rnd_q == 6'd0)
  `ASSERT_IMPL(busy_covers_run, clk_i, rst_ni, run_q |-> ctrl_i.busy)

endmodule
